@@ design/gcb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants of the glyph column blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COLOR_RED    = 3'd2;
  localparam logic [2:0] REG_COLOR_GREEN  = 3'd3;
  localparam logic [2:0] REG_COLOR_BLUE   = 3'd4;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic MODE_RGB565 = 1'b0;
  localparam logic MODE_YUV422 = 1'b1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_GLYPH_HEIGHT  = 64;
  localparam int DEF_MAX_GLYPH_COLUMNS = 255;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam int RST_FRAME_WIDTH  = 320;
  localparam int RST_FRAME_HEIGHT = 240;
  localparam int RST_RED          = 255;
  localparam int RST_GREEN        = 0;
  localparam int RST_BLUE         = 0;

  // Q16 color conversion coefficients (magnitudes, signs applied in the sum)
  localparam int KY_R = 16828;
  localparam int KY_G = 33036;
  localparam int KY_B = 6416;
  localparam int KU_R = 9713;
  localparam int KU_G = 19069;
  localparam int KU_B = 28783;
  localparam int KV_R = 28783;
  localparam int KV_G = 24102;
  localparam int KV_B = 4681;
  localparam int OFS_Y  = 16 << 16;
  localparam int OFS_UV = 128 << 16;

  // Converted colour after reset (red text)
  localparam logic [7:0] RST_Y = 8'd81;
  localparam logic [7:0] RST_U = 8'd90;
  localparam logic [7:0] RST_V = 8'd239;

  // Current configuration as seen by front and back
  typedef struct packed {
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic        color_mode;
    logic [15:0] rgb565;
    logic [7:0]  yuv_y;
    logic [7:0]  yuv_u;
    logic [7:0]  yuv_v;
  } gcb_cfg_t;

  // One queued job: the visible pixels of one font byte
  typedef struct packed {
    logic [7:0]         mask;
    logic [9:0]         col;
    logic signed [11:0] row0;
  } gcb_job_t;

  localparam int JOB_W = $bits(gcb_job_t);

endpackage

`default_nettype wire

@@ design/gcb_color.sv @@
// ----------------------------------------------------------------------------
// gcb_color
// Configuration registers and the two-stage RGB to YUV conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_color (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gcb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [gcb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output gcb_pkg::gcb_cfg_t                      cfg
);

  logic [9:0] fw_r, fh_r;
  logic [7:0] red_r, green_r, blue_r;
  logic       mode_r;

  // stage 1: constant products
  logic [23:0] pyr_r, pyg_r, pyb_r;
  logic [23:0] pur_r, pug_r, pub_r;
  logic [23:0] pvr_r, pvg_r, pvb_r;
  // stage 2: offset, sum, clamp
  logic [7:0]  y_r, u_r, v_r;

  logic signed [25:0] sum_y, sum_u, sum_v;

  function automatic logic [7:0] q16_to_byte(input logic signed [25:0] q);
    logic [7:0] res;
    if (q < 0) begin
      res = 8'd0;
    end else if (q > 26'sh0FF_FFFF) begin
      res = 8'd255;
    end else begin
      res = q[23:16];
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= 10'(gcb_pkg::RST_FRAME_WIDTH);
      fh_r    <= 10'(gcb_pkg::RST_FRAME_HEIGHT);
      red_r   <= 8'(gcb_pkg::RST_RED);
      green_r <= 8'(gcb_pkg::RST_GREEN);
      blue_r  <= 8'(gcb_pkg::RST_BLUE);
      mode_r  <= gcb_pkg::MODE_RGB565;
    end else if (cfg_valid) begin
      case (cfg_addr)
        gcb_pkg::REG_FRAME_WIDTH:  fw_r    <= cfg_data[9:0];
        gcb_pkg::REG_FRAME_HEIGHT: fh_r    <= cfg_data[9:0];
        gcb_pkg::REG_COLOR_RED:    red_r   <= cfg_data[7:0];
        gcb_pkg::REG_COLOR_GREEN:  green_r <= cfg_data[7:0];
        gcb_pkg::REG_COLOR_BLUE:   blue_r  <= cfg_data[7:0];
        gcb_pkg::REG_COLOR_MODE:   mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pyr_r <= 24'(gcb_pkg::KY_R * gcb_pkg::RST_RED);
      pyg_r <= 24'(gcb_pkg::KY_G * gcb_pkg::RST_GREEN);
      pyb_r <= 24'(gcb_pkg::KY_B * gcb_pkg::RST_BLUE);
      pur_r <= 24'(gcb_pkg::KU_R * gcb_pkg::RST_RED);
      pug_r <= 24'(gcb_pkg::KU_G * gcb_pkg::RST_GREEN);
      pub_r <= 24'(gcb_pkg::KU_B * gcb_pkg::RST_BLUE);
      pvr_r <= 24'(gcb_pkg::KV_R * gcb_pkg::RST_RED);
      pvg_r <= 24'(gcb_pkg::KV_G * gcb_pkg::RST_GREEN);
      pvb_r <= 24'(gcb_pkg::KV_B * gcb_pkg::RST_BLUE);
      y_r   <= gcb_pkg::RST_Y;
      u_r   <= gcb_pkg::RST_U;
      v_r   <= gcb_pkg::RST_V;
    end else begin
      pyr_r <= 24'(gcb_pkg::KY_R * red_r);
      pyg_r <= 24'(gcb_pkg::KY_G * green_r);
      pyb_r <= 24'(gcb_pkg::KY_B * blue_r);
      pur_r <= 24'(gcb_pkg::KU_R * red_r);
      pug_r <= 24'(gcb_pkg::KU_G * green_r);
      pub_r <= 24'(gcb_pkg::KU_B * blue_r);
      pvr_r <= 24'(gcb_pkg::KV_R * red_r);
      pvg_r <= 24'(gcb_pkg::KV_G * green_r);
      pvb_r <= 24'(gcb_pkg::KV_B * blue_r);
      y_r   <= q16_to_byte(sum_y);
      u_r   <= q16_to_byte(sum_u);
      v_r   <= q16_to_byte(sum_v);
    end
  end

  always_comb begin
    sum_y = 26'(gcb_pkg::OFS_Y) + $signed({2'b00, pyr_r}) + $signed({2'b00, pyg_r})
          + $signed({2'b00, pyb_r});
    sum_u = 26'(gcb_pkg::OFS_UV) - $signed({2'b00, pur_r}) - $signed({2'b00, pug_r})
          + $signed({2'b00, pub_r});
    sum_v = 26'(gcb_pkg::OFS_UV) + $signed({2'b00, pvr_r}) - $signed({2'b00, pvg_r})
          - $signed({2'b00, pvb_r});
  end

  always_comb begin
    cfg.frame_width  = fw_r;
    cfg.frame_height = fh_r;
    cfg.color_mode   = mode_r;
    cfg.rgb565       = {red_r[7:3], green_r[7:2], blue_r[7:3]};
    cfg.yuv_y        = y_r;
    cfg.yuv_u        = u_r;
    cfg.yuv_v        = v_r;
  end

endmodule

`default_nettype wire

@@ design/gcb_front.sv @@
// ----------------------------------------------------------------------------
// gcb_front
// Takes font bytes, tracks glyph column position, clips against the frame
// and queues the mask of visible pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_front #(
  parameter int MAX_GLYPH_HEIGHT  = gcb_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int MAX_GLYPH_COLUMNS = gcb_pkg::DEF_MAX_GLYPH_COLUMNS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               glyph_start,
  input  wire logic signed [10:0] x_origin,
  input  wire logic signed [10:0] y_origin,
  input  wire logic [6:0]         glyph_height,
  input  wire logic [7:0]         font_byte,
  input  wire gcb_pkg::gcb_cfg_t  cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output gcb_pkg::gcb_job_t       q_job
);

  localparam int BYTES_MAX = (MAX_GLYPH_HEIGHT + 7) / 8;
  localparam int BIC_W     = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;
  localparam int COL_W     = $clog2(MAX_GLYPH_COLUMNS + 1);

  logic [BIC_W-1:0]   bic_r, bic_nxt, bic_eff;
  logic [COL_W-1:0]   col_r, col_nxt, col_eff;
  logic signed [10:0] lx_r, lx_nxt, ly_r, ly_nxt;
  logic [6:0]         lh_r, lh_nxt, h_clamp;

  logic               accept, active, last_byte, col_ok;
  logic signed [11:0] colpos, row0;
  logic signed [12:0] rowb;
  logic [7:0]         row_ok, mask;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (glyph_height == 7'd0) begin
      h_clamp = 7'd1;
    end else if (glyph_height > 7'(MAX_GLYPH_HEIGHT)) begin
      h_clamp = 7'(MAX_GLYPH_HEIGHT);
    end else begin
      h_clamp = glyph_height;
    end

    lx_nxt  = glyph_start ? x_origin : lx_r;
    ly_nxt  = glyph_start ? y_origin : ly_r;
    lh_nxt  = glyph_start ? h_clamp  : lh_r;
    bic_eff = glyph_start ? '0 : bic_r;
    col_eff = glyph_start ? '0 : col_r;

    active    = col_eff < COL_W'(MAX_GLYPH_COLUMNS);
    last_byte = bic_eff == BIC_W'((lh_nxt - 7'd1) >> 3);

    bic_nxt = bic_eff;
    col_nxt = col_eff;
    if (active) begin
      if (last_byte) begin
        bic_nxt = '0;
        col_nxt = col_eff + COL_W'(1);
      end else begin
        bic_nxt = bic_eff + BIC_W'(1);
      end
    end

    // clip column and each of the eight rows against the frame
    colpos = 12'(lx_nxt) + $signed(12'(col_eff));
    col_ok = !colpos[11] && (colpos[10:0] < {1'b0, cfg.frame_width});
    row0   = 12'(ly_nxt) + $signed(12'({bic_eff, 3'b000}));
    rowb   = '0;
    for (int b = 0; b < 8; b++) begin
      rowb      = 13'(row0) + 13'(b);
      row_ok[b] = !rowb[12] && (rowb[11:0] < {2'b00, cfg.frame_height});
    end
    mask = font_byte & row_ok & {8{col_ok}};

    q_job.mask = mask;
    q_job.col  = colpos[9:0];
    q_job.row0 = row0;
    q_push     = accept && active && (mask != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bic_r <= '0;
      col_r <= '0;
      lx_r  <= '0;
      ly_r  <= '0;
      lh_r  <= 7'd1;
    end else if (accept) begin
      bic_r <= bic_nxt;
      col_r <= col_nxt;
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      lh_r  <= lh_nxt;
    end
  end

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(MAX_GLYPH_COLUMNS))
    else $error("column counter past glyph limit");

  a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bic_r <= BIC_W'((lh_r - 7'd1) >> 3))
    else $error("byte counter past column height");

endmodule

`default_nettype wire

@@ design/gcb_queue.sv @@
// ----------------------------------------------------------------------------
// gcb_queue
// Small first-in first-out job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_queue #(
  parameter int W     = gcb_pkg::JOB_W,
  parameter int DEPTH = gcb_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_r];

  always_comb begin
    wr_nxt  = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    rd_nxt  = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_nxt;
      if (pop)  rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job queue underflow");

endmodule

`default_nettype wire

@@ design/gcb_back.sv @@
// ----------------------------------------------------------------------------
// gcb_back
// Walks the set bits of each queued job into the output register, one
// framebuffer write per cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gcb_pkg::gcb_job_t q_job,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire gcb_pkg::gcb_cfg_t cfg,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [19:0]            pixel_address,
  output logic [15:0]            pixel_word,
  output logic                   run_last
);

  logic               cur_valid_r, cur_valid_nxt;
  logic [7:0]         cur_mask_r, cur_mask_nxt;
  logic [9:0]         cur_col_r, cur_col_nxt;
  logic signed [11:0] cur_row_r, cur_row_nxt;

  logic               out_valid_r;
  logic [19:0]        out_addr_r;
  logic               out_last_r;

  logic               free, emit, load;
  logic [2:0]         bit_idx;
  logic [7:0]         onehot, rem;
  logic [11:0]        row;
  logic [19:0]        prod, addr;

  always_comb begin
    // lowest set bit first: top pixel first
    bit_idx = '0;
    for (int b = 7; b >= 0; b--) begin
      if (cur_mask_r[b]) bit_idx = 3'(b);
    end
    onehot = 8'd1 << bit_idx;
    rem    = cur_mask_r & ~onehot;

    free  = !out_valid_r || out_ready;
    emit  = cur_valid_r && free;
    load  = !q_empty && (!cur_valid_r || (emit && rem == 8'd0));
    q_pop = load;

    row  = 12'(cur_row_r) + 12'(bit_idx);
    prod = row[9:0] * cfg.frame_width;
    addr = prod + 20'(cur_col_r);

    cur_valid_nxt = cur_valid_r;
    cur_mask_nxt  = cur_mask_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_mask_nxt  = q_job.mask;
      cur_col_nxt   = q_job.col;
      cur_row_nxt   = q_job.row0;
    end else if (emit) begin
      cur_mask_nxt  = rem;
      cur_valid_nxt = rem != 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_mask_r <= cur_mask_nxt;
    cur_col_r  <= cur_col_nxt;
    cur_row_r  <= cur_row_nxt;
    if (emit) begin
      out_addr_r <= addr;
      out_last_r <= rem == 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign pixel_address = out_addr_r;
  assign run_last      = out_last_r;
  // colour registers must change only while idle (not enforced): word follows
  assign pixel_word    = (cfg.color_mode == gcb_pkg::MODE_YUV422) ?
                         {cfg.yuv_y, (out_addr_r[0] ? cfg.yuv_v : cfg.yuv_u)} :
                         cfg.rgb565;

  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_mask_r != 8'd0))
    else $error("active job with no pixels left");

endmodule

`default_nettype wire

@@ design/glyph_column_blit_framebuffer_top.sv @@
// ----------------------------------------------------------------------------
// glyph_column_blit_framebuffer_top
// Glyph column blitter: font bytes in, 16-bit framebuffer writes out.
// ----------------------------------------------------------------------------
// Input stream: one column-major font byte per item; tuser set on the first
// byte of a glyph latches origin and height. Output stream: one framebuffer
// write per item (pixel index and word), tlast on the last write of a byte.
// Bytes with no visible set pixel produce no output.
// Configuration: write-only register port, always ready; write only while
// the stream is idle. Colour changes pass the product and sum registers.
// Path: the first write of a byte passes through the job queue, the current
// job register and the output register.
// Flow: the back end issues one write per cycle while the receiver is ready,
// so a byte with n visible pixels (up to 8) makes n writes; the front end
// takes one byte per cycle while the four-entry job queue has room.
// Reset: counters cleared, height 1, 320x240 frame, red text, RGB565 mode;
// no clearing pass is needed.
// Receiver stall: the output register holds, the back end pauses, the queue
// fills and then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_column_blit_framebuffer_top #(
  parameter int MAX_GLYPH_HEIGHT  = gcb_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int MAX_GLYPH_COLUMNS = gcb_pkg::DEF_MAX_GLYPH_COLUMNS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // x_origin[10:0], y_origin[21:11], glyph_height[28:22], font_byte[36:29]
  input  wire logic [39:0]                    in_tdata,
  // glyph_start[0]
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pixel_address[19:0], pixel_word[35:20], zero fill above
  output logic [39:0]                         out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gcb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [gcb_pkg::CFG_DATA_W-1:0] cfg_data
);

  gcb_pkg::gcb_cfg_t cfg;
  gcb_pkg::gcb_job_t push_job, head_job;
  logic [gcb_pkg::JOB_W-1:0] head_bits;
  logic        q_full, q_empty, q_push, q_pop;
  logic [19:0] pixel_address;
  logic [15:0] pixel_word;

  gcb_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gcb_front #(
    .MAX_GLYPH_HEIGHT  (MAX_GLYPH_HEIGHT),
    .MAX_GLYPH_COLUMNS (MAX_GLYPH_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .glyph_start  (in_tuser),
    .x_origin     ($signed(in_tdata[10:0])),
    .y_origin     ($signed(in_tdata[21:11])),
    .glyph_height (in_tdata[28:22]),
    .font_byte    (in_tdata[36:29]),
    .cfg          (cfg),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  gcb_queue #(
    .W     (gcb_pkg::JOB_W),
    .DEPTH (gcb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_bits),
    .empty (q_empty)
  );

  assign head_job = gcb_pkg::gcb_job_t'(head_bits);

  gcb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_job         (head_job),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .pixel_address (pixel_address),
    .pixel_word    (pixel_word),
    .run_last      (out_tlast)
  );

  assign out_tdata = {4'b0000, pixel_word, pixel_address};

endmodule

`default_nettype wire

@@ dv/glyph_column_blit_framebuffer_top_tb.sv @@
// ----------------------------------------------------------------------------
// glyph_column_blit_framebuffer_top_tb
// Self-checking bench for the glyph column blitter. Font bytes are driven
// on the input stream, first as a short table of directed bytes and then as
// random glyphs, under several frame and colour settings. A predictor works
// out the framebuffer writes of every accepted byte. Each write on the
// output stream is checked against the oldest predicted one. Both stream
// sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_column_blit_framebuffer_top_tb;

  localparam int MAX_HT     = gcb_pkg::DEF_MAX_GLYPH_HEIGHT;
  localparam int MAX_COLS   = gcb_pkg::DEF_MAX_GLYPH_COLUMNS;
  localparam int DRAIN      = 32;
  localparam int CYCLE_CAP  = 200000;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 20;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [19:0] addr;
    logic [15:0] word;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    logic        st;
    logic [10:0] x;
    logic [10:0] y;
    logic [6:0]  h;
    logic [7:0]  fb;
    logic        gold;
    logic [19:0] gold_a;
    logic [15:0] gold_w;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [gcb_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gcb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // typed-in expectation travelling with the item
  logic        gold_on = 1'b0;
  logic [19:0] gold_addr = '0;
  logic [15:0] gold_word = '0;

  bit idle_on = 1'b1;
  int mismatches = 0;
  int cycles = 0;

  fb_write_t pending_writes[$];

  // blitter shadow state
  logic [9:0]         fw, fh;
  logic [7:0]         cr, cg, cb;
  logic               cm;
  logic [2:0]         byte_row;
  logic [7:0]         col_idx;
  logic signed [10:0] org_x, org_y;
  logic [6:0]         ht;
  logic [15:0]        rgb_word;
  logic [7:0]         y_lvl, u_lvl, v_lvl;

  byte_row_t dir_rows [0:N_DIRECTED-1];

  glyph_column_blit_framebuffer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("glyph_column_blit_framebuffer_top_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 6);
  end

  function automatic logic [7:0] q16_sat(input int q);
    if (q < 0) return 8'd0;
    if (q > 'hFFFFFF) return 8'd255;
    return q[23:16];
  endfunction

  function void recolor();
    int r, g, b;
    r = int'(cr);
    g = int'(cg);
    b = int'(cb);
    rgb_word = {cr[7:3], cg[7:2], cb[7:3]};
    y_lvl = q16_sat(gcb_pkg::OFS_Y + gcb_pkg::KY_R * r + gcb_pkg::KY_G * g
                    + gcb_pkg::KY_B * b);
    u_lvl = q16_sat(gcb_pkg::OFS_UV - gcb_pkg::KU_R * r - gcb_pkg::KU_G * g
                    + gcb_pkg::KU_B * b);
    v_lvl = q16_sat(gcb_pkg::OFS_UV + gcb_pkg::KV_R * r - gcb_pkg::KV_G * g
                    - gcb_pkg::KV_B * b);
  endfunction

  function void reset_shadow();
    fw = 10'(gcb_pkg::RST_FRAME_WIDTH);
    fh = 10'(gcb_pkg::RST_FRAME_HEIGHT);
    cr = 8'(gcb_pkg::RST_RED);
    cg = 8'(gcb_pkg::RST_GREEN);
    cb = 8'(gcb_pkg::RST_BLUE);
    cm = gcb_pkg::MODE_RGB565;
    byte_row = '0;
    col_idx = '0;
    org_x = '0;
    org_y = '0;
    ht = 7'd1;
    recolor();
  endfunction

  function void apply_reg(input logic [gcb_pkg::CFG_ADDR_W-1:0] idx,
                          input logic [gcb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      gcb_pkg::REG_FRAME_WIDTH:  fw = val[9:0];
      gcb_pkg::REG_FRAME_HEIGHT: fh = val[9:0];
      gcb_pkg::REG_COLOR_RED:    cr = val[7:0];
      gcb_pkg::REG_COLOR_GREEN:  cg = val[7:0];
      gcb_pkg::REG_COLOR_BLUE:   cb = val[7:0];
      gcb_pkg::REG_COLOR_MODE:   cm = val[0];
      default: return;
    endcase
    recolor();
  endfunction

  // Queue the framebuffer writes caused by one font byte
  function void blit_byte(input logic st, input logic [39:0] d);
    logic [6:0]  h;
    logic [7:0]  fb;
    logic [19:0] addr;
    logic [19:0] addr_a [0:7];
    logic [15:0] word_a [0:7];
    int col, row0, row, n, raster, nb;
    h = d[28:22];
    fb = d[36:29];
    if (st) begin
      if (h == 0) h = 7'd1;
      if (int'(h) > MAX_HT) h = 7'(MAX_HT);
      org_x = d[10:0];
      org_y = d[21:11];
      ht = h;
      byte_row = '0;
      col_idx = '0;
    end
    if (int'(col_idx) >= MAX_COLS) return;
    col = int'(org_x) + int'(col_idx);
    row0 = int'(org_y) + 8 * int'(byte_row);
    n = 0;
    for (int b = 0; b < 8; b++) begin
      row = row0 + b;
      if (fb[b] && col >= 0 && col < int'(fw) && row >= 0 && row < int'(fh)) begin
        addr = 20'(row * int'(fw) + col);
        addr_a[n] = addr;
        word_a[n] = (cm == gcb_pkg::MODE_RGB565) ? rgb_word
                                                 : {y_lvl, addr[0] ? v_lvl : u_lvl};
        n++;
      end
    end
    for (int i = 0; i < n; i++) pending_writes.push_back({addr_a[i], word_a[i], i == n - 1});
    raster = 1 + ((int'(ht) - 1) >> 3);
    nb = int'(byte_row) + 1;
    if (nb >= raster) begin
      byte_row = '0;
      col_idx = col_idx + 8'd1;
    end else begin
      byte_row = nb[2:0];
    end
  endfunction

  always @(posedge clk) begin : monitor_blk
    fb_write_t want;
    int n0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) begin
        n0 = pending_writes.size();
        blit_byte(in_tuser, in_tdata);
        if (gold_on) begin
          if (pending_writes.size() != n0 + 1) begin
            $error("write count: expected 1, actual %0d", pending_writes.size() - n0);
            mismatches++;
          end else if (pending_writes[$].addr != gold_addr ||
                       pending_writes[$].word != gold_word) begin
            $error("directed write: expected %0d/%h, predicted %0d/%h", gold_addr, gold_word,
                   pending_writes[$].addr, pending_writes[$].word);
            mismatches++;
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_writes.size() == 0) begin
          $error("unexpected write: pixel_address %0d pixel_word %h",
                 out_tdata[19:0], out_tdata[35:20]);
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          if (out_tdata[19:0] != want.addr) begin
            $error("pixel_address: expected %0d, actual %0d", want.addr, out_tdata[19:0]);
            mismatches++;
          end
          if (out_tdata[35:20] != want.word) begin
            $error("pixel_word: expected %h, actual %h", want.word, out_tdata[35:20]);
            mismatches++;
          end
          if (out_tlast != want.last) begin
            $error("run_last: expected %0b, actual %0b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic st, input logic [10:0] x, input logic [10:0] y,
                           input logic [6:0] h, input logic [7:0] fb,
                           input logic g_on, input logic [19:0] g_a, input logic [15:0] g_w);
    while (idle_on && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= st;
    in_tdata  <= {3'b000, fb, h, y, x};
    gold_on   <= g_on;
    gold_addr <= g_a;
    gold_word <= g_w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender holds off until every predicted write has come out
  task automatic drain_expected(input int extra);
    in_tvalid <= 1'b0;
    gold_on <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gcb_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [gcb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int r, input int g, input int b,
                           input logic mode);
    drain_expected(DRAIN);
    write_reg(gcb_pkg::REG_FRAME_WIDTH, 10'(w));
    write_reg(gcb_pkg::REG_FRAME_HEIGHT, 10'(h));
    // colour registers ignore the upper data bits
    write_reg(gcb_pkg::REG_COLOR_RED, {2'($urandom), 8'(r)});
    write_reg(gcb_pkg::REG_COLOR_GREEN, {2'($urandom), 8'(g)});
    write_reg(gcb_pkg::REG_COLOR_BLUE, {2'($urandom), 8'(b)});
    write_reg(gcb_pkg::REG_COLOR_MODE, {9'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [10:0] pick_origin(input logic [9:0] span);
    if ($urandom_range(9) == 0) return 11'($urandom);
    return 11'(int'($urandom_range(int'(span) + 12)) - 8);
  endfunction

  function automatic logic [7:0] pick_font_byte();
    if ($urandom_range(9) == 0) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed glyphs, a few restarted mid-glyph
  task automatic send_random_glyph(inout int sent);
    int sel, h_raw, hc, raster, ncols;
    sel = $urandom_range(99);
    if (sel < 5) h_raw = 0;
    else if (sel < 10) h_raw = $urandom_range(127, 65);
    else if (sel < 70) h_raw = $urandom_range(16, 1);
    else h_raw = $urandom_range(64, 1);
    hc = (h_raw == 0) ? 1 : ((h_raw > MAX_HT) ? MAX_HT : h_raw);
    raster = 1 + ((hc - 1) >> 3);
    ncols = $urandom_range(5, 1);
    send_byte(1'b1, pick_origin(fw), pick_origin(fh), 7'(h_raw), pick_font_byte(), 1'b0, '0, '0);
    sent++;
    for (int i = 1; i < ncols * raster; i++) begin
      if ($urandom_range(99) < 3)
        send_byte(1'b1, pick_origin(fw), pick_origin(fh), 7'($urandom), pick_font_byte(),
                  1'b0, '0, '0);
      else
        send_byte(1'b0, 11'($urandom), 11'($urandom), 7'($urandom), pick_font_byte(),
                  1'b0, '0, '0);
      sent++;
    end
  endtask

  initial begin : stim
    int sent;
    reset_shadow();
    dir_rows = '{
      '{1'b1, 11'd0,    11'd0,    7'd1,   8'h01, 1'b1, 20'd0,     16'hF800},
      '{1'b1, 11'd319,  11'd239,  7'd1,   8'h01, 1'b1, 20'd76799, 16'hF800},
      '{1'b1, 11'd0,    11'd0,    7'd8,   8'h80, 1'b1, 20'd2240,  16'hF800},
      '{1'b1, 11'd319,  11'd239,  7'd1,   8'h02, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'h7FF,  11'd0,    7'd8,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'd320,  11'd10,   7'd8,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'h3FF,  11'h3FF,  7'd64,  8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'h400,  11'h400,  7'd1,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'd10,   11'h7FC,  7'd8,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'd5,    11'd5,    7'd0,   8'h81, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'h555,  11'h2AA,  7'h55,  8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'd100,  11'd100,  7'd127, 8'h80, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'h2AA,  11'h555,  7'h2A,  8'h01, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'h55, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'hAA, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'h00, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'h0F, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'hF0, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'd0,    11'd0,    7'd0,   8'h3C, 1'b0, 20'd0,     16'h0},
      '{1'b1, 11'd200,  11'd50,   7'd3,   8'hFF, 1'b0, 20'd0,     16'h0},
      '{1'b0, 11'h7FF,  11'h7FF,  7'h7F,  8'h07, 1'b0, 20'd0,     16'h0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(dir_rows[i].st, dir_rows[i].x, dir_rows[i].y, dir_rows[i].h, dir_rows[i].fb,
                dir_rows[i].gold, dir_rows[i].gold_a, dir_rows[i].gold_w);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_frame(1023, 1023, 255, 255, 255, gcb_pkg::MODE_YUV422);
        1: begin
          set_frame(1, 1, 0, 0, 0, gcb_pkg::MODE_RGB565);
          @(posedge clk);
          // unmapped index must leave the registers alone
          write_reg(REG_UNUSED, 10'h3FF);
          cfg_valid <= 1'b0;
        end
        2: set_frame(0, 240, 255, 0, 0, gcb_pkg::MODE_RGB565);
        3: set_frame(320, 0, 0, 255, 0, gcb_pkg::MODE_YUV422);
        4: set_frame(64, 48, 0, 0, 255, gcb_pkg::MODE_YUV422);
        default: set_frame($urandom_range(1023, 1), $urandom_range(1023, 1), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255), 1'($urandom));
      endcase
      idle_on = (p != 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_glyph(sent);
        if (p == 6 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 8)
          drain_expected(0);
      end
    end
    idle_on = 1'b1;

    drain_expected(DRAIN);
    if (mismatches == 0)
      $display("glyph_column_blit_framebuffer_top_tb: done, clean");
    else
      $display("glyph_column_blit_framebuffer_top_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
